@@ hdl/link_format4_response_receiver_macros.svh @@
// Assertion helpers for the format-4 reply receiver.
`ifndef LINK_FORMAT4_RESPONSE_RECEIVER_MACROS_SVH
`define LINK_FORMAT4_RESPONSE_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LF4RR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LF4RR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lf4rr_pkg.sv @@
package lf4rr_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_SUM1 = 3'd2;
  localparam logic [2:0] PH_SUM2 = 3'd3;
  localparam logic [2:0] PH_TRL1 = 3'd4;
  localparam logic [2:0] PH_TRL2 = 3'd5;
  localparam logic [2:0] PH_ACKR = 3'd6;
  localparam logic [2:0] PH_NAKR = 3'd7;

  localparam logic [3:0] EV_HDR      = 4'd0;
  localparam logic [3:0] EV_PAY      = 4'd1;
  localparam logic [3:0] EV_OK       = 4'd2;
  localparam logic [3:0] EV_SUMERR   = 4'd3;
  localparam logic [3:0] EV_ACK      = 4'd4;
  localparam logic [3:0] EV_NAK      = 4'd5;
  localparam logic [3:0] EV_BADLEAD  = 4'd6;
  localparam logic [3:0] EV_TIMEOUT  = 4'd7;
  localparam logic [3:0] EV_OVERFLOW = 4'd8;

  localparam logic [11:0] HDR_BYTES   = 12'd4;
  localparam logic [11:0] ACK_REST    = 12'd6;
  localparam logic [11:0] NAK_REST    = 12'd8;
  localparam logic [11:0] NAK_CODE_HI = 12'd5;
  localparam logic [11:0] NAK_CODE_LO = 12'd6;

  localparam logic REG_MAX_FRAME = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam logic [11:0] MAX_FRAME_RST = 12'd256;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd40;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
    logic       stx;
    logic       etx;
    logic       ack;
    logic       nak;
  } lf4rr_item_t;

  typedef struct packed {
    logic [11:0] max_frame;
    logic [7:0]  timeout;
  } lf4rr_cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       emit;
    logic [3:0] ev;
  } lf4rr_stat_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h37 + {4'h0, nib};
  endfunction

endpackage

@@ hdl/lf4rr_front.sv @@
module lf4rr_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] rx_byte
  input  logic                in_tuser,   // [0] is_tick
  input  logic                q_full,
  output logic                push,
  output lf4rr_pkg::lf4rr_item_t push_item
);
  import lf4rr_pkg::*;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_item.is_tick = in_tuser;
    push_item.data    = in_tdata;
    push_item.stx     = (in_tdata == CH_STX);
    push_item.etx     = (in_tdata == CH_ETX);
    push_item.ack     = (in_tdata == CH_ACK);
    push_item.nak     = (in_tdata == CH_NAK);
  end

endmodule

@@ hdl/lf4rr_queue.sv @@
module lf4rr_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lf4rr_pkg::lf4rr_item_t push_item,
  input  logic                   pop,
  output logic                   q_valid,
  output logic                   q_full,
  output lf4rr_pkg::lf4rr_item_t q_item
);
  import lf4rr_pkg::*;

  lf4rr_item_t entries_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_item  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/lf4rr_back.sv @@
module lf4rr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lf4rr_pkg::lf4rr_cfg_t  cfg,
  input  logic                   q_valid,
  input  lf4rr_pkg::lf4rr_item_t q_item,
  output logic                   pop,
  output lf4rr_pkg::lf4rr_stat_t stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,  // [15:0] value
  output logic [3:0]             out_tuser   // [3:0] event_res
);
  import lf4rr_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] held_r, held_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic        out_valid_r;
  logic [3:0]  out_ev_r;
  logic [15:0] out_val_r;

  logic        back_ready;
  logic        emit;
  logic        go_idle;
  logic [3:0]  ev;
  logic [15:0] val;
  logic [11:0] cnt_inc;
  logic        sum_good;

  assign back_ready = !out_valid_r || out_tready;
  assign pop        = q_valid && back_ready;
  assign cnt_inc    = cnt_r + 12'd1;
  assign sum_good   = (held_r[7:0] == hex_upper(sum_r[7:4])) &&
                      (cnt_r[7:0] == hex_upper(sum_r[3:0]));

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    idle_nxt  = idle_r;
    emit      = 1'b0;
    go_idle   = 1'b0;
    ev        = EV_HDR;
    val       = 16'h0000;
    if (pop) begin
      if (q_item.is_tick) begin
        if (phase_r != PH_IDLE) begin
          if (idle_r >= cfg.timeout) begin
            go_idle = 1'b1;
            emit    = 1'b1;
            ev      = EV_TIMEOUT;
          end else begin
            idle_nxt = idle_r + 8'd1;
          end
        end
      end else begin
        idle_nxt = 8'd0;
        unique case (phase_r)
          PH_IDLE: begin
            if (q_item.stx) begin
              phase_nxt = PH_BODY;
              cnt_nxt   = 12'd0;
              sum_nxt   = 8'd0;
            end else if (q_item.ack) begin
              phase_nxt = PH_ACKR;
              cnt_nxt   = 12'd0;
            end else if (q_item.nak) begin
              phase_nxt = PH_NAKR;
              cnt_nxt   = 12'd0;
              held_nxt  = 16'h0000;
            end else begin
              emit = 1'b1;
              ev   = EV_BADLEAD;
              val  = {8'h00, q_item.data};
            end
          end
          PH_BODY: begin
            if (cnt_r >= cfg.max_frame) begin
              go_idle = 1'b1;
              emit    = 1'b1;
              ev      = EV_OVERFLOW;
            end else begin
              cnt_nxt = cnt_inc;
              sum_nxt = sum_r + q_item.data;
              if (q_item.etx) begin
                phase_nxt = PH_SUM1;
              end else begin
                emit = 1'b1;
                ev   = (cnt_inc <= HDR_BYTES) ? EV_HDR : EV_PAY;
                val  = {8'h00, q_item.data};
              end
            end
          end
          PH_SUM1: begin
            held_nxt  = {8'h00, q_item.data};
            phase_nxt = PH_SUM2;
          end
          PH_SUM2: begin
            cnt_nxt   = {4'h0, q_item.data};
            phase_nxt = PH_TRL1;
          end
          PH_TRL1: begin
            phase_nxt = PH_TRL2;
          end
          PH_TRL2: begin
            go_idle = 1'b1;
            emit    = 1'b1;
            if (sum_good) begin
              ev = EV_OK;
            end else begin
              ev  = EV_SUMERR;
              val = {held_r[7:0], cnt_r[7:0]};
            end
          end
          PH_ACKR: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= ACK_REST) begin
              go_idle = 1'b1;
              emit    = 1'b1;
              ev      = EV_ACK;
            end
          end
          PH_NAKR: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc == NAK_CODE_HI) begin
              held_nxt = {8'h00, q_item.data};
            end else if (cnt_inc == NAK_CODE_LO) begin
              held_nxt = {held_r[7:0], q_item.data};
            end else if (cnt_inc >= NAK_REST) begin
              go_idle = 1'b1;
              emit    = 1'b1;
              ev      = EV_NAK;
              val     = held_r;
            end
          end
          default: begin
            go_idle = 1'b1;
          end
        endcase
      end
      if (go_idle) begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = 12'd0;
        sum_nxt   = 8'd0;
        held_nxt  = 16'h0000;
        idle_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= 12'd0;
      sum_r       <= 8'd0;
      held_r      <= 16'h0000;
      idle_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
      idle_r  <= idle_nxt;
      if (back_ready) begin
        out_valid_r <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_ev_r  <= ev;
      out_val_r <= val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_ev_r;

  always_comb begin
    stat.phase = phase_r;
    stat.emit  = pop && emit;
    stat.ev    = ev;
  end

endmodule

@@ hdl/link_format4_response_receiver.sv @@
// Format-4 serial link reply receiver. Each input beat carries one received
// character, or a time tick when in_tuser is set; each output beat reports a
// header or payload byte, a good frame, a sum error with the received sum
// characters, an ACK, a NAK with its error code, a bad lead byte, a timeout
// or an overflow. Beats flow at one per clock unless the output stalls: a
// two-entry queue sits between the classifying front end and the frame state
// machine, and a registered output stage holds a waiting result while new
// beats fill the queue. Write the frame limit (index 0) and the timeout
// (index 1) only while no frame is in flight.
`include "link_format4_response_receiver_macros.svh"

module link_format4_response_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tuser,    // [0] is_tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] value
  output logic [3:0]  out_tuser,   // [3:0] event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import lf4rr_pkg::*;

  logic        push;
  logic        pop;
  logic        q_valid;
  logic        q_full;
  lf4rr_item_t push_item;
  lf4rr_item_t q_item;
  lf4rr_stat_t stat;
  lf4rr_cfg_t  cfg;
  logic [11:0] max_frame_r;
  logic [7:0]  timeout_r;
  logic        body_ev;
  logic        close_ev;
  logic        quiet_ev;

  assign cfg_ready     = 1'b1;
  assign cfg.max_frame = max_frame_r;
  assign cfg.timeout   = timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_FRAME: max_frame_r <= cfg_data;
        REG_TIMEOUT:   timeout_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lf4rr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lf4rr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  lf4rr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign body_ev  = stat.emit && (stat.ev == EV_HDR || stat.ev == EV_PAY);
  assign close_ev = stat.emit && (stat.ev == EV_TIMEOUT || stat.ev == EV_OVERFLOW ||
                                  stat.ev == EV_NAK || stat.ev == EV_ACK);
  assign quiet_ev = out_tvalid && (out_tuser == EV_OK || out_tuser == EV_ACK ||
                                   out_tuser == EV_TIMEOUT || out_tuser == EV_OVERFLOW);

  `LF4RR_ASSERT_NOW(a_body_events, body_ev, stat.phase == PH_BODY, "data event outside frame body")
  `LF4RR_ASSERT_NEXT(a_end_idle, close_ev, stat.phase == PH_IDLE, "closing event left frame open")
  `LF4RR_ASSERT_NOW(a_zero_value, quiet_ev, out_tdata == 16'h0000, "value not zero for valueless event")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import lf4rr_pkg::*;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] value;
  } reply_event_t;

  class reply_book;
    reply_event_t pending[$];
    int unsigned  errors;
    logic [11:0]  frame_limit;
    logic [7:0]   tick_limit;
    logic [2:0]   ph;
    logic [11:0]  count;
    logic [7:0]   sum;
    logic [15:0]  held;
    logic [7:0]   idle;

    function void restart();
      ph    = PH_IDLE;
      count = '0;
      sum   = '0;
      held  = '0;
      idle  = '0;
    endfunction

    function void power_up();
      frame_limit = MAX_FRAME_RST;
      tick_limit  = TIMEOUT_RST;
      errors      = 0;
      pending.delete();
      restart();
    endfunction

    function void set_reg(logic idx, logic [11:0] d);
      if (idx == REG_MAX_FRAME) begin
        frame_limit = d;
      end else begin
        tick_limit = d[7:0];
      end
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) begin
        return 8'h30 + {4'h0, n};
      end
      return 8'h41 + {4'h0, n} - 8'd10;
    endfunction

    function void push(logic [3:0] code, logic [15:0] value);
      reply_event_t e;
      e.code  = code;
      e.value = value;
      pending.push_back(e);
    endfunction

    function void note_beat(logic tick, logic [7:0] b);
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [15:0] code;
      if (tick) begin
        if (ph == PH_IDLE) begin
          return;
        end
        if (idle >= tick_limit) begin
          restart();
          push(EV_TIMEOUT, 16'h0000);
          return;
        end
        idle = idle + 8'd1;
        return;
      end
      idle = '0;
      case (ph)
        PH_IDLE: begin
          if (b == CH_STX) begin
            ph    = PH_BODY;
            count = '0;
            sum   = '0;
          end else if (b == CH_ACK) begin
            ph    = PH_ACKR;
            count = '0;
          end else if (b == CH_NAK) begin
            ph    = PH_NAKR;
            count = '0;
            held  = '0;
          end else begin
            push(EV_BADLEAD, {8'h00, b});
          end
        end
        PH_BODY: begin
          if (count >= frame_limit) begin
            restart();
            push(EV_OVERFLOW, 16'h0000);
          end else begin
            count = count + 12'd1;
            sum   = sum + b;
            if (b == CH_ETX) begin
              ph = PH_SUM1;
            end else begin
              push((count <= HDR_BYTES) ? EV_HDR : EV_PAY, {8'h00, b});
            end
          end
        end
        PH_SUM1: begin
          held = {8'h00, b};
          ph   = PH_SUM2;
        end
        PH_SUM2: begin
          count = {4'h0, b};
          ph    = PH_TRL1;
        end
        PH_TRL1: begin
          ph = PH_TRL2;
        end
        PH_TRL2: begin
          c1 = held[7:0];
          c2 = count[7:0];
          if (c1 == hex_char(sum[7:4]) && c2 == hex_char(sum[3:0])) begin
            restart();
            push(EV_OK, 16'h0000);
          end else begin
            restart();
            push(EV_SUMERR, {c1, c2});
          end
        end
        PH_ACKR: begin
          count = count + 12'd1;
          if (count >= ACK_REST) begin
            restart();
            push(EV_ACK, 16'h0000);
          end
        end
        default: begin
          count = count + 12'd1;
          if (count == NAK_CODE_HI) begin
            held = {8'h00, b};
          end else if (count == NAK_CODE_LO) begin
            held = {held[7:0], b};
          end else if (count >= NAK_REST) begin
            code = held;
            restart();
            push(EV_NAK, code);
          end
        end
      endcase
    endfunction

    function void check_event(logic [3:0] code, logic [15:0] value);
      reply_event_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, code %0d value %h", $time, code, value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (code !== want.code) begin
        $display("%0t: code mismatch, expected %0d, got %0d", $time, want.code, code);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: value mismatch, expected %h, got %h", $time, want.value, value);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [11:0] cfg_data   = 12'h000;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [3:0]  out_tuser;
  wire         cfg_ready;

  logic        in_gaps    = 1'b1;
  logic        out_gaps   = 1'b1;
  logic        hold_out   = 1'b0;
  int unsigned beats_sent = 0;
  reply_book   book;

  link_format4_response_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_beat(logic tick, logic [7:0] b);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= tick;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_beat(tick, b);
    beats_sent++;
  endtask

  task automatic pause_ticks(int n);
    repeat (n) send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_frame(int body_len, int fault, logic with_ticks);
    logic [7:0] s;
    logic [7:0] b;
    logic [7:0] c1;
    logic [7:0] c2;
    s = 8'h00;
    send_beat(1'b0, CH_STX);
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(255));
      if (b == CH_ETX) begin
        b = b ^ 8'h80;
      end
      s = s + b;
      send_beat(1'b0, b);
      if (with_ticks && $urandom_range(9) == 0) begin
        pause_ticks($urandom_range(book.tick_limit < 8 ? book.tick_limit : 8));
      end
    end
    s = s + CH_ETX;
    send_beat(1'b0, CH_ETX);
    c1 = book.hex_char(s[7:4]);
    c2 = book.hex_char(s[3:0]);
    if (fault == 1) begin
      c1 = 8'($urandom_range(255));
    end else if (fault == 2) begin
      c1 = c1 | 8'h20;
      c2 = c2 | 8'h20;
    end
    send_beat(1'b0, c1);
    send_beat(1'b0, c2);
    send_beat(1'b0, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h0D);
    send_beat(1'b0, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h0A);
  endtask

  task automatic send_ack();
    send_beat(1'b0, CH_ACK);
    repeat (6) send_beat(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic send_nak();
    send_beat(1'b0, CH_NAK);
    for (int i = 1; i <= 8; i++) begin
      if (i == 5 || i == 6) begin
        send_beat(1'b0, book.hex_char(4'($urandom_range(15))));
      end else begin
        send_beat(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        out_tready <= !out_gaps || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      book.check_event(out_tuser, out_tdata);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [11:0] frame_lims[6];
    logic [7:0]  tick_lims[6];
    int unsigned target;
    int          pick;
    int          len;
    book = new();
    book.power_up();
    frame_lims = '{12'd256, 12'd4095, 12'd1, 12'd12, 12'd0, 12'd30};
    tick_lims  = '{8'd40, 8'd255, 8'd1, 8'd3, 8'd0, 8'd8};
    frame_lims[4] = 12'($urandom_range(2, 40));
    tick_lims[4]  = 8'($urandom_range(2, 20));
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_ack();
    send_nak();
    // short header ended by ETX, sum 0xAB sent in lower case
    send_beat(1'b0, CH_STX);
    send_beat(1'b0, 8'h50);
    send_beat(1'b0, 8'h58);
    send_beat(1'b0, CH_ETX);
    send_beat(1'b0, 8'h61);
    send_beat(1'b0, 8'h62);
    send_beat(1'b0, 8'h0D);
    send_beat(1'b0, 8'h0A);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        while (book.ph != PH_IDLE) send_beat(1'b1, 8'($urandom_range(255)));
        wait_drained();
        write_reg(REG_MAX_FRAME, frame_lims[p]);
        write_reg(REG_TIMEOUT, {4'h0, tick_lims[p]});
      end
      in_gaps  = (p != 1);
      out_gaps = (p != 1);
      if (p == 0) begin
        hold_out = 1'b1;
        send_frame(100, 0, 1'b0);
        wait_drained();
      end
      target = beats_sent + 110;
      while (beats_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          len = $urandom_range(12);
          if (book.frame_limit <= 40 && $urandom_range(3) == 0) begin
            len = int'(book.frame_limit) - 1 + $urandom_range(2);
          end
          send_frame(len, ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 2), 1'b1);
        end else if (pick < 57) begin
          send_ack();
        end else if (pick < 69) begin
          send_nak();
        end else if (pick < 82) begin
          repeat ($urandom_range(1, 4)) begin
            send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
          end
        end else if (pick < 90 && book.tick_limit <= 40) begin
          case ($urandom_range(2))
            0: send_beat(1'b0, CH_STX);
            1: send_beat(1'b0, CH_ACK);
            default: send_beat(1'b0, CH_NAK);
          endcase
          pause_ticks(int'(book.tick_limit) + $urandom_range(1));
        end else begin
          send_beat(1'b0, CH_STX);
          repeat ($urandom_range(1, 3)) send_beat(1'b0, 8'($urandom_range(255)));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
